FILE: rtl/apool_pkg.sv
// Shared types, constants and helper tables for the 2-D average pooling block.
// Used by every module in rtl/; depends on nothing else.
package apool_pkg;

    // Image and window geometry
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int WIN_ROWS   = 3;
    localparam int WIN_COLS   = 3;

    // Field and counter widths
    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 6;
    localparam int DIM_W    = 7;
    localparam int STEP_W   = 3;
    localparam int LINE_W   = SAMPLE_W * (WIN_ROWS - 1);

    // Column sum of three samples, window sum of nine, magnitude of that sum
    localparam int COLSUM_W = SAMPLE_W + 2;
    localparam int SUM_W    = SAMPLE_W + 4;
    localparam int ABS_W    = SUM_W - 1;

    // Division by the window area (9) as a multiply by a rounded-up reciprocal.
    // The error term 4 * 294912 stays below 2^23, so the quotient is exact.
    localparam int RECIP_SHIFT  = 23;
    localparam int RECIP_MULT_W = 20;
    localparam logic [RECIP_MULT_W-1:0] RECIP_MULT = 20'd932068;
    localparam int PROD_W       = ABS_W + RECIP_MULT_W;

    // Queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_STEP_SIZE    = 2'd2
    } cfg_reg_t;

    // Configuration register values as written
    typedef struct packed {
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
        logic [STEP_W-1:0] step_size;
    } pool_cfg_t;

    // One pooled window on its way to the back part: three column sums,
    // oldest column first, and the end-of-image mark.
    typedef struct packed {
        logic signed [COLSUM_W-1:0] col_sum0;
        logic signed [COLSUM_W-1:0] col_sum1;
        logic signed [COLSUM_W-1:0] col_sum2;
        logic                       last;
    } pool_item_t;

    // Bit i is set when position i is a multiple of the step.
    typedef logic [MAX_WIDTH-1:0] step_mask_t;

    function automatic step_mask_t build_step_mask(input int unsigned step);
        int unsigned cnt;
        step_mask_t  mask;
        cnt  = 0;
        mask = '0;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            mask[i] = (cnt == 0);
            cnt++;
            if (cnt == step) begin
                cnt = 0;
            end
        end
        return mask;
    endfunction

    localparam step_mask_t STEP_MASK [0:7] = '{
        build_step_mask(0), build_step_mask(1), build_step_mask(2), build_step_mask(3),
        build_step_mask(4), build_step_mask(5), build_step_mask(6), build_step_mask(7)
    };

endpackage

FILE: rtl/apool_front.sv
// Front part: accepts samples, tracks the raster position, holds the line memory
// and the running column sums, and classifies which samples close a pooled window.
// Depends on apool_pkg.
module apool_front
    import apool_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  pool_cfg_t           cfg,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,
    input  logic [QUEUE_CW-1:0] queue_level,
    output logic                push_valid,
    output pool_item_t          push_item
);

    // Position counters and the stage that follows the line memory read
    logic [POS_W-1:0]    col_reg, col_next;
    logic [POS_W-1:0]    row_reg, row_next;
    logic                st0_valid_reg;
    logic                st0_emit_reg;
    logic                st0_last_reg;
    logic [POS_W-1:0]    st0_col_reg;
    logic [SAMPLE_W-1:0] st0_sample_reg;
    logic [LINE_W-1:0]   rd_data_reg;
    logic signed [COLSUM_W-1:0] cs_a_reg, cs_b_reg;

    logic [LINE_W-1:0]   line_mem [MAX_WIDTH];

    logic [DIM_W-1:0]    width_eff, height_eff;
    logic [STEP_W-1:0]   step_eff;
    logic [POS_W-1:0]    col_eff, row_eff;
    logic [POS_W-1:0]    top, left;
    logic [DIM_W-1:0]    col_inc, row_inc;
    logic [DIM_W:0]      row_reach, col_reach;
    logic                accept;
    logic                emit, last_row, last_col;
    logic signed [COLSUM_W-1:0] col_sum_new;

    // Effective geometry: sizes saturate to the window and the maximum, step 0 acts as 1
    always_comb begin
        if (cfg.image_width < DIM_W'(WIN_COLS)) begin
            width_eff = DIM_W'(WIN_COLS);
        end else if (cfg.image_width > DIM_W'(MAX_WIDTH)) begin
            width_eff = DIM_W'(MAX_WIDTH);
        end else begin
            width_eff = cfg.image_width;
        end
        if (cfg.image_height < DIM_W'(WIN_ROWS)) begin
            height_eff = DIM_W'(WIN_ROWS);
        end else if (cfg.image_height > DIM_W'(MAX_HEIGHT)) begin
            height_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            height_eff = cfg.image_height;
        end
        step_eff = (cfg.step_size == '0) ? STEP_W'(1) : cfg.step_size;
    end

    // A position left beyond a smaller size wraps to zero before use
    assign col_eff = ({1'b0, col_reg} >= width_eff)  ? '0 : col_reg;
    assign row_eff = ({1'b0, row_reg} >= height_eff) ? '0 : row_reg;

    // Room in the queue for this sample and the one still in the read stage
    assign s_tready = ({1'b0, queue_level} + {{QUEUE_CW{1'b0}}, st0_valid_reg})
                      < (QUEUE_CW + 1)'(QUEUE_DEPTH);
    assign accept   = s_tvalid && s_tready;

    // Window classification: full window, corner on the step grid, last one in the image
    always_comb begin
        top       = row_eff - POS_W'(WIN_ROWS - 1);
        left      = col_eff - POS_W'(WIN_COLS - 1);
        row_reach = {2'b00, row_eff} + (DIM_W + 1)'(1) + {{(DIM_W + 1 - STEP_W){1'b0}}, step_eff};
        col_reach = {2'b00, col_eff} + (DIM_W + 1)'(1) + {{(DIM_W + 1 - STEP_W){1'b0}}, step_eff};
        last_row  = row_reach > {1'b0, height_eff};
        last_col  = col_reach > {1'b0, width_eff};
        emit      = (row_eff >= POS_W'(WIN_ROWS - 1)) && (col_eff >= POS_W'(WIN_COLS - 1))
                    && STEP_MASK[step_eff][top] && STEP_MASK[step_eff][left];
    end

    // Raster advance
    always_comb begin
        col_inc  = {1'b0, col_eff} + DIM_W'(1);
        row_inc  = {1'b0, row_eff} + DIM_W'(1);
        col_next = col_inc[POS_W-1:0];
        row_next = row_eff;
        if (col_inc >= width_eff) begin
            col_next = '0;
            row_next = (row_inc >= height_eff) ? '0 : row_inc[POS_W-1:0];
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            st0_valid_reg <= 1'b0;
        end else begin
            st0_valid_reg <= accept;
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // Payload of the read stage
    always_ff @(posedge aclk) begin
        if (accept) begin
            st0_sample_reg <= s_tdata;
            st0_col_reg    <= col_eff;
            st0_emit_reg   <= emit;
            st0_last_reg   <= last_row && last_col;
        end
    end

    // Line memory: read at acceptance, written back in the next cycle.
    // Low half holds the older row, high half the newer one.
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= line_mem[col_eff];
        end
        if (st0_valid_reg) begin
            line_mem[st0_col_reg] <= {st0_sample_reg, rd_data_reg[LINE_W-1:SAMPLE_W]};
        end
    end

    // Sum of the new window column
    assign col_sum_new = COLSUM_W'($signed(rd_data_reg[SAMPLE_W-1:0]))
                       + COLSUM_W'($signed(rd_data_reg[LINE_W-1:SAMPLE_W]))
                       + COLSUM_W'($signed(st0_sample_reg));

    // Shift the column sums of the window
    always_ff @(posedge aclk) begin
        if (st0_valid_reg) begin
            cs_a_reg <= cs_b_reg;
            cs_b_reg <= col_sum_new;
        end
    end

    // Hand a closed window to the queue
    assign push_valid         = st0_valid_reg && st0_emit_reg;
    assign push_item.col_sum0 = cs_a_reg;
    assign push_item.col_sum1 = cs_b_reg;
    assign push_item.col_sum2 = col_sum_new;
    assign push_item.last     = st0_last_reg;

    // Every accepted sample reaches the read stage in the next cycle
    a_stage_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> st0_valid_reg)
        else $error("accepted sample did not reach the read stage");

    // The write-back never targets the column being read in the same cycle
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (st0_valid_reg && accept) |-> (st0_col_reg != col_eff))
        else $error("line memory read and write-back hit the same column");

endmodule

FILE: rtl/apool_queue.sv
// Short queue of pooled windows between the front and back parts.
// Depends on apool_pkg.
module apool_queue
    import apool_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    input  pool_item_t          push_item,
    input  logic                pop,
    output logic                head_valid,
    output pool_item_t          head_item,
    output logic [QUEUE_CW-1:0] level
);

    pool_item_t          entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic                do_pop;

    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign level      = count_reg;
    assign do_pop     = pop && head_valid;

    // Occupancy after this cycle's push and pop
    always_comb begin
        count_next = count_reg;
        if (push_valid && !do_pop) begin
            count_next = count_reg + QUEUE_CW'(1);
        end else if (!push_valid && do_pop) begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    // Pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push_valid) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push_valid) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue occupancy beyond its depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> (count_reg < QUEUE_CW'(QUEUE_DEPTH)))
        else $error("window pushed into a full queue");

endmodule

FILE: rtl/apool_back.sv
// Back part: adds the column sums, divides by the window area with a reciprocal
// multiply, truncates toward zero and holds the result in the output register.
// Depends on apool_pkg.
module apool_back
    import apool_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  pool_item_t          head_item,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_tdata,
    output logic                m_tlast
);

    logic                     p1_valid_reg, p2_valid_reg, p3_valid_reg, out_valid_reg;
    logic                     p1_last_reg, p2_last_reg, p3_last_reg, out_last_reg;
    logic signed [SUM_W-1:0]  p1_sum_reg;
    logic                     p2_neg_reg, p3_neg_reg;
    logic [ABS_W-1:0]         p2_abs_reg;
    logic [PROD_W-1:0]        p3_prod_reg;
    logic [SAMPLE_W-1:0]      out_data_reg;

    logic                     advance;
    logic signed [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]         neg_sum;
    logic [SAMPLE_W-1:0]      quotient;

    // The whole pipeline moves when the output register is free or being taken
    assign advance = !out_valid_reg || m_tready;
    assign pop     = advance && head_valid;

    assign sum      = SUM_W'(head_item.col_sum0) + SUM_W'(head_item.col_sum1)
                    + SUM_W'(head_item.col_sum2);
    assign neg_sum  = -p1_sum_reg;
    assign quotient = p3_prod_reg[PROD_W-1:RECIP_SHIFT];

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            p1_valid_reg  <= head_valid;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            out_valid_reg <= p3_valid_reg;
        end
    end

    // Data path: sum, magnitude, reciprocal product, sign restore
    always_ff @(posedge aclk) begin
        if (advance) begin
            p1_sum_reg   <= sum;
            p1_last_reg  <= head_item.last;
            p2_neg_reg   <= p1_sum_reg[SUM_W-1];
            p2_abs_reg   <= p1_sum_reg[SUM_W-1] ? neg_sum[ABS_W-1:0]
                                                : p1_sum_reg[ABS_W-1:0];
            p2_last_reg  <= p1_last_reg;
            p3_prod_reg  <= PROD_W'(p2_abs_reg) * PROD_W'(RECIP_MULT);
            p3_neg_reg   <= p2_neg_reg;
            p3_last_reg  <= p2_last_reg;
            out_data_reg <= p3_neg_reg ? -quotient : quotient;
            out_last_reg <= p3_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_out_from_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(p3_valid_reg))
        else $error("result appeared without a window in the last stage");

endmodule

FILE: rtl/average_pool_2d_top.sv
// Top level of the 3x3 average pooling block: configuration registers and the
// front part, queue and back part. Depends on apool_pkg and the apool_* modules.
//
// The block takes one signed Q8.8 sample per clock in raster order and gives the
// mean of each full 3x3 window whose top-left corner lies on the step grid, as
// signed Q8.8 truncated toward zero; m_tlast marks the last window of the image.
// Sustained rate is one sample per cycle while the output does not stall. A result
// moves from the sample that closes its window through the line memory read stage,
// where the column sum forms, then the queue, then the add, magnitude and
// reciprocal-multiply stages; the sign is restored on the way into the output
// register. A four-entry queue between the front and back parts absorbs output
// stalls; s_tready drops only while that queue and the sample in the line memory
// read stage would fill it. The line memory has no clearing pass.
module average_pool_2d_top
    import apool_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Configuration writes
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [DIM_W-1:0]    cfg_data,
    // Sample stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // [15:0] sample
    // Result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // [15:0] average
    output logic                m_tlast    // final_flag
);

    pool_cfg_t           cfg_reg;
    logic                push_valid;
    pool_item_t          push_item;
    logic                head_valid;
    pool_item_t          head_item;
    logic                pop;
    logic [QUEUE_CW-1:0] queue_level;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width  <= DIM_W'(64);
            cfg_reg.image_height <= DIM_W'(64);
            cfg_reg.step_size    <= STEP_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data;
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data;
                REG_STEP_SIZE:    cfg_reg.step_size    <= cfg_data[STEP_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    apool_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .queue_level (queue_level),
        .push_valid  (push_valid),
        .push_item   (push_item)
    );

    apool_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .level      (queue_level)
    );

    apool_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
